### rtl/core/fsnr_pkg.sv
// ============================================================================
// fsnr_pkg: shared types, constants and word-fold function
// Net kinds, register selects, field widths and the per-kind fold of two
// four-state words (aval/bval planes: 00=0, 10=1, 01=x, 11=z).
// ============================================================================
package fsnr_pkg;

    // Field widths
    localparam int DATA_W      = 64;
    localparam int STR_W       = 3;
    localparam int WORD_BITS   = 64;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 128;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Live bits of the net word; bits above WORD_BITS read as zero
    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

    // Per-bit value codes of the strength fold: {bval, aval}
    localparam logic [1:0] VAL_X = 2'b10;
    localparam logic [1:0] VAL_Z = 2'b11;

    typedef enum logic [2:0] {
        NET_WIRE,
        NET_WAND,
        NET_WOR,
        NET_TRI0,
        NET_TRI1,
        NET_SUPPLY0,
        NET_SUPPLY1,
        NET_TRIREG
    } net_kind_t;

    // Register select, taken from paddr[2]
    typedef enum logic {
        REG_NET_KIND,
        REG_STRENGTH_MODE
    } reg_sel_t;

    typedef struct packed {
        logic [DATA_W-1:0] aval;
        logic [DATA_W-1:0] bval;
    } plane_pair_t;

    // Control for the strength fold lanes
    typedef struct packed {
        logic             en;
        logic             first;
        logic [STR_W-1:0] s0;
        logic [STR_W-1:0] s1;
    } fold_ctrl_t;

    // Fold driver y into accumulated word x by the net kind's rule
    function automatic plane_pair_t fold_word(
        input net_kind_t         kind,
        input logic [DATA_W-1:0] xa,
        input logic [DATA_W-1:0] xb,
        input logic [DATA_W-1:0] ya,
        input logic [DATA_W-1:0] yb
    );
        logic [DATA_W-1:0] xz, yz, both, xonly, yonly, none, xx, yx, pa, pb;
        logic [DATA_W-1:0] zero, unk, one, clash;
        plane_pair_t       r;
        xz    = xa & xb;
        yz    = ya & yb;
        both  = xz & yz;
        xonly = xz & ~yz;
        yonly = yz & ~xz;
        none  = ~xz & ~yz;
        xx    = ~xa & xb;
        yx    = ~ya & yb;
        pa    = both | (ya & xonly) | (xa & yonly);
        pb    = both | (yb & xonly) | (xb & yonly);
        case (kind)
            NET_WAND: begin
                zero   = ((~xa & ~xb) | (~ya & ~yb)) & none;
                unk    = (xx | yx) & none & ~zero;
                one    = xa & ~xb & ya & ~yb & none;
                r.aval = pa | one;
                r.bval = pb | unk;
            end
            NET_WOR: begin
                one    = ((xa & ~xb) | (ya & ~yb)) & none;
                unk    = (xx | yx) & none & ~one;
                r.aval = pa | one;
                r.bval = pb | unk;
            end
            default: begin
                // wire rule: z yields, known bits that disagree give x
                clash  = ~xb & ~yb & (xa ^ ya);
                unk    = (xx | yx | clash) & none;
                r.aval = pa | (xa & none & ~unk);
                r.bval = pb | unk;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/fsnr_strength_fold.sv
// ============================================================================
// fsnr_strength_fold: per-bit strongest-wins fold
// One lane per net bit holds best strength, best value and a conflict flag.
// A driver folds into all lanes at once; the resolved planes reflect
// the lane state after the current driver.
// ============================================================================
module fsnr_strength_fold
    import fsnr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  fold_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] drv_aval,
    input  logic [DATA_W-1:0] drv_bval,
    output logic [DATA_W-1:0] lane_aval,
    output logic [DATA_W-1:0] lane_bval
);

    logic [STR_W-1:0]     best_s_reg    [WORD_BITS];
    logic [STR_W-1:0]     best_s_next   [WORD_BITS];
    logic [1:0]           best_v_reg    [WORD_BITS];
    logic [1:0]           best_v_next   [WORD_BITS];
    logic [WORD_BITS-1:0] conflict_reg;
    logic [WORD_BITS-1:0] conflict_next;

    // Lane update: start from empty on a first driver, then fold
    always_comb begin
        logic [STR_W-1:0] cur_s;
        logic [1:0]       cur_v;
        logic             cur_c;
        logic [1:0]       v;
        logic [STR_W-1:0] s;
        logic [1:0]       rv;
        lane_aval = '0;
        lane_bval = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            cur_s = ctrl.first ? '0    : best_s_reg[i];
            cur_v = ctrl.first ? VAL_Z : best_v_reg[i];
            cur_c = ctrl.first ? 1'b0  : conflict_reg[i];
            v     = {drv_bval[i], drv_aval[i]};
            case (v)
                2'b00:   s = ctrl.s0;
                2'b01:   s = ctrl.s1;
                default: s = (ctrl.s0 > ctrl.s1) ? ctrl.s0 : ctrl.s1;
            endcase
            best_s_next[i]   = cur_s;
            best_v_next[i]   = cur_v;
            conflict_next[i] = cur_c;
            // z bits take no part
            if (v != VAL_Z) begin
                if (s > cur_s) begin
                    best_s_next[i]   = s;
                    best_v_next[i]   = v;
                    conflict_next[i] = 1'b0;
                end else if (s == cur_s && v != cur_v) begin
                    conflict_next[i] = 1'b1;
                end
            end
            rv           = conflict_next[i] ? VAL_X : best_v_next[i];
            lane_aval[i] = rv[0];
            lane_bval[i] = rv[1];
        end
    end

    // Lane state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                best_s_reg[i] <= '0;
                best_v_reg[i] <= VAL_Z;
            end
            conflict_reg <= '0;
        end else if (ctrl.en) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                best_s_reg[i] <= best_s_next[i];
                best_v_reg[i] <= best_v_next[i];
            end
            conflict_reg <= conflict_next;
        end
    end

`ifndef SYNTHESIS
    // An all-z first driver leaves every lane free of conflict
    a_first_z_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.en && ctrl.first && ((drv_aval & drv_bval & WORD_MASK) == WORD_MASK))
        |=> (conflict_reg == '0))
        else $error("conflict left after all-z first driver");

    // Lanes hold while no driver folds
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.en |=> $stable(conflict_reg))
        else $error("conflict flags changed without a driver");
`endif

endmodule

### rtl/core/four_state_net_resolver_top.sv
// ============================================================================
// four_state_net_resolver_top: four-state net word resolver
// Folds driver words of one 64-bit net word by wire/wand/wor rules or by
// per-bit strength, applies tri0/tri1 pulls, supply constants and trireg
// charge hold, and sends the resolved word on the last driver.
//
// Channel    Dir  Handshake          Carries
// s_axis     in   s_tvalid/s_tready  one driver word (tlast = last driver)
// m_axis     out  m_tvalid/m_tready  one resolved word per last driver
// apb        in   psel/penable       net_kind (0x0), strength_mode (0x4)
//
// One item accepted per cycle while the result is not stalled; the last
// driver is taken into the input register and its fold lands in the result
// register, which raises m_tvalid.
// Reset is synchronous and clears all fold state at once; no clearing pass.
// A stalled result holds both stages and drops s_tready until it is taken.
// ============================================================================
module four_state_net_resolver_top
    import fsnr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Driver items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [63:0] drv_aval, [127:64] drv_bval, [130:128] drv_strength0,
    // [133:131] drv_strength1, [135:134] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,   // last_driver
    input  logic                   s_tuser,   // [0] first_driver
    // Resolved items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [63:0] net_aval, [127:64] net_bval
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    net_kind_t         net_kind_reg;
    logic              strength_mode_reg;
    reg_sel_t          reg_sel;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_aval_reg;
    logic [DATA_W-1:0] in_bval_reg;
    logic [STR_W-1:0]  in_s0_reg;
    logic [STR_W-1:0]  in_s1_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    logic [DATA_W-1:0] acc_aval_reg, acc_aval_next;
    logic [DATA_W-1:0] acc_bval_reg, acc_bval_next;
    logic              all_z_reg, all_z_next;
    logic [DATA_W-1:0] held_aval_reg;
    logic [DATA_W-1:0] held_bval_reg;

    logic              out_valid_reg, out_valid_next;
    plane_pair_t       out_data_reg;

    logic              advance;
    logic              fire;
    logic [DATA_W-1:0] da, db;
    logic              drv_z;
    plane_pair_t       folded;
    plane_pair_t       res;
    logic [DATA_W-1:0] str_aval, str_bval;
    logic [DATA_W-1:0] zbits;
    fold_ctrl_t        fold_ctrl;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = reg_sel_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_kind_reg      <= NET_WIRE;
            strength_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_NET_KIND:      net_kind_reg      <= net_kind_t'(pwdata[2:0]);
                REG_STRENGTH_MODE: strength_mode_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_NET_KIND:      prdata = {{(APB_DATA_W-3){1'b0}}, net_kind_reg};
            REG_STRENGTH_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, strength_mode_reg};
            default:           prdata = '0;
        endcase
    end

    // Both stages move together unless the result waits
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign fire     = advance && in_valid_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_aval_reg  <= s_tdata[DATA_W-1:0];
            in_bval_reg  <= s_tdata[2*DATA_W-1:DATA_W];
            in_s0_reg    <= s_tdata[2*DATA_W+STR_W-1:2*DATA_W];
            in_s1_reg    <= s_tdata[2*DATA_W+2*STR_W-1:2*DATA_W+STR_W];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // Strength fold lanes
    assign fold_ctrl.en    = fire;
    assign fold_ctrl.first = in_first_reg;
    assign fold_ctrl.s0    = in_s0_reg;
    assign fold_ctrl.s1    = in_s1_reg;

    fsnr_strength_fold u_strength_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fold_ctrl),
        .drv_aval  (da),
        .drv_bval  (db),
        .lane_aval (str_aval),
        .lane_bval (str_bval)
    );

    // Word fold and resolution
    always_comb begin
        da     = in_aval_reg & WORD_MASK;
        db     = in_bval_reg & WORD_MASK;
        drv_z  = ((da & db) == WORD_MASK);
        folded = fold_word(net_kind_reg, acc_aval_reg, acc_bval_reg, da, db);
        if (in_first_reg) begin
            acc_aval_next = da;
            acc_bval_next = db;
            all_z_next    = drv_z;
        end else begin
            acc_aval_next = folded.aval & WORD_MASK;
            acc_bval_next = folded.bval & WORD_MASK;
            all_z_next    = all_z_reg && drv_z;
        end

        // Selected fold, with pulls for tri0/tri1, supply constants and trireg hold
        if (strength_mode_reg) begin
            res.aval = str_aval;
            res.bval = str_bval;
        end else begin
            res.aval = acc_aval_next;
            res.bval = acc_bval_next;
        end
        zbits = res.aval & res.bval;
        case (net_kind_reg)
            NET_SUPPLY0: begin
                res.aval = '0;
                res.bval = '0;
            end
            NET_SUPPLY1: begin
                res.aval = WORD_MASK;
                res.bval = '0;
            end
            NET_TRIREG: begin
                if (all_z_next) begin
                    res.aval = held_aval_reg;
                    res.bval = held_bval_reg;
                end
            end
            NET_TRI0: begin
                res.aval = res.aval & ~zbits;
                res.bval = res.bval & ~zbits;
            end
            NET_TRI1: begin
                res.aval = res.aval | zbits;
                res.bval = res.bval & ~zbits;
            end
            default: ;
        endcase
        res.aval = res.aval & WORD_MASK;
        res.bval = res.bval & WORD_MASK;
    end

    // Fold state and held charge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_aval_reg  <= '0;
            acc_bval_reg  <= '0;
            all_z_reg     <= 1'b1;
            held_aval_reg <= '0;
            held_bval_reg <= '1;
        end else if (fire) begin
            acc_aval_reg <= acc_aval_next;
            acc_bval_reg <= acc_bval_next;
            all_z_reg    <= all_z_next;
            if (in_last_reg) begin
                held_aval_reg <= res.aval;
                held_bval_reg <= res.bval;
            end
        end
    end

    // Result register
    assign out_valid_next = advance ? (in_valid_reg && in_last_reg) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.bval, out_data_reg.aval};

`ifndef SYNTHESIS
    // A new result only follows a last driver in the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg && in_last_reg))
        else $error("result without a last driver");

    // supply0 always resolves to all 0
    a_supply0: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last_reg && net_kind_reg == NET_SUPPLY0) |=> (m_tdata == '0))
        else $error("supply0 result not zero");

    // A first driver that is not all z clears the all-z flag
    a_all_z_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_first_reg && !drv_z) |=> !all_z_reg)
        else $error("all-z flag kept after driven first word");
`endif

endmodule
